>>> sv/slst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slst_pkg
// Types, codes and constants shared by the station link statistics table.
// ----------------------------------------------------------------------------
package slst_pkg;

    localparam int DEF_ENTRIES = 32;
    localparam int DEF_NUM_AP  = 16;
    localparam int MAX_RESULTS = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic signed [7:0] THRESH_RST = -8'sd65;
    localparam logic [7:0]        PERIOD_RST = 8'd1;
    localparam logic [15:0]       LIMIT_RST  = 16'd180;

    localparam logic [1:0] REG_THRESH = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_LIMIT0 = 2'd2;
    localparam logic [1:0] REG_LIMIT1 = 2'd3;

    localparam logic [3:0] DEAUTH_AP_LIMIT = 4'd2;
    localparam logic [1:0] REASON_PASSWORD = 2'd1;

    typedef enum logic [2:0] {
        CMD_POLL     = 3'd0,
        CMD_POLL_END = 3'd1,
        CMD_CONNECT  = 3'd2,
        CMD_DISCON   = 3'd3,
        CMD_DEAUTH   = 3'd4,
        CMD_REPORT   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_DISCARD   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_SWEEP,
        S_REPORT,
        S_OUT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [3:0]        ap_id;
        logic [47:0]       station_mac;
        logic signed [7:0] signal;
        logic [1:0]        reason;
        logic [31:0]       now_seconds;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        password_fail;
        logic        rapid_reconnect;
        logic        entry_valid;
        logic [47:0] rep_mac;
        logic [31:0] rep_good_time;
        logic [31:0] rep_bad_time;
        logic [31:0] rep_total_connected;
        logic [31:0] rep_total_disconnected;
        logic [15:0] rep_reconnects;
        logic        last;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request
        logic scan;      // examine entry at index, advance
        logic apply;     // apply single-entry command
        logic sweep;     // poll end on entry at index, advance
        logic rep_rd;    // read entry at index for report
        logic rep_wr;    // write back reported entry, advance
        logic clr_idx;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic scan_end;
        logic idx_match;  // entry at index belongs to request AP
        logic idx_end;
        logic discard;
        logic is_report;
        logic is_sweep;
        logic any_rep;
        logic rep_cap;
    } t_sts;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

>>> sv/slst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slst_ctrl
// Sequencer: capture, scan, apply or sweep or report, deliver result.
// ----------------------------------------------------------------------------
module slst_ctrl import slst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    output logic o_out_last_en,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_ctl         = '0;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_out_last_en = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load    = 1'b1;
                    o_ctl.clr_idx = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.discard) begin
                    n_state = S_DONE;
                end else if (i_sts.is_sweep) begin
                    n_state = S_SWEEP;
                end else if (i_sts.is_report) begin
                    n_state = S_REPORT;
                end else begin
                    o_ctl.scan = 1'b1;
                    if (i_sts.scan_end) begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_APPLY: begin
                o_ctl.apply = 1'b1;
                n_state     = S_DONE;
            end
            S_SWEEP: begin
                o_ctl.sweep = 1'b1;
                if (i_sts.idx_end) begin
                    n_state = S_DONE;
                end
            end
            S_REPORT: begin
                if (i_sts.idx_match && i_sts.rep_cap) begin
                    o_ctl.rep_rd = 1'b1;
                    n_state      = S_OUT;
                end else if (i_sts.idx_end) begin
                    n_state = S_DONE;
                end else begin
                    o_ctl.rep_wr = 1'b0;
                    o_ctl.scan   = 1'b1;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_ctl.rep_wr = 1'b1;
                    n_state      = i_sts.idx_end ? S_DONE : S_REPORT;
                end
            end
            S_DONE: begin
                if (i_sts.is_report && i_sts.any_rep && !i_sts.discard) begin
                    n_state = S_IDLE;
                end else begin
                    o_out_valid   = 1'b1;
                    o_out_last_en = 1'b1;
                    if (i_out_ready) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> sv/slst_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slst_dp
// Entry table, index counter, lookup and counter update datapath.
// ----------------------------------------------------------------------------
module slst_dp import slst_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES,
    parameter int NUM_AP  = DEF_NUM_AP
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_req               i_req,
    input  t_ctl               i_ctl,
    input  logic               i_out_last_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_cfg_we,
    output t_sts               o_sts,
    output t_rsp               o_rsp
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int RW = $clog2(MAX_RESULTS + 1);

    logic signed [7:0] r_thresh;
    logic [7:0]        r_period;
    logic [15:0]       r_lim0, r_lim1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RST;
            r_period <= PERIOD_RST;
            r_lim0   <= LIMIT_RST;
            r_lim1   <= LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_THRESH: r_thresh <= i_cfg_data[7:0];
                REG_PERIOD: r_period <= i_cfg_data[7:0];
                REG_LIMIT0: r_lim0   <= i_cfg_data;
                REG_LIMIT1: r_lim1   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [ENTRIES-1:0] r_used, r_seen;
    logic [3:0]  m_ap   [ENTRIES];
    logic [47:0] m_mac  [ENTRIES];
    logic [31:0] m_good [ENTRIES];
    logic [31:0] m_bad  [ENTRIES];
    logic [31:0] m_con  [ENTRIES];
    logic [31:0] m_dis  [ENTRIES];
    logic [31:0] m_tcon [ENTRIES];
    logic [31:0] m_tdis [ENTRIES];
    logic [31:0] m_lct  [ENTRIES];
    logic [15:0] m_rc   [ENTRIES];

    t_req          r_req;
    logic [CW-1:0] r_idx;
    logic          r_hit, r_free_ok;
    logic [IW-1:0] r_hit_idx, r_free_idx;
    logic [RW-1:0] r_nrep;
    t_rsp          r_rsp;

    logic [IW-1:0] idx;
    logic          at_end, match, discard;
    assign idx    = r_idx[IW-1:0];
    assign at_end = (r_idx == CW'(ENTRIES - 1));
    assign match  = r_used[idx] && (m_ap[idx] == r_req.ap_id);
    assign discard = ({1'b0, r_req.ap_id} >= 5'(NUM_AP)) || (r_req.cmd > CMD_REPORT)
        || (r_req.cmd == CMD_DEAUTH && r_req.ap_id >= DEAUTH_AP_LIMIT);

    assign o_sts.scan_end  = at_end;
    assign o_sts.idx_match = match;
    assign o_sts.idx_end   = at_end;
    assign o_sts.discard   = discard;
    assign o_sts.is_report = (r_req.cmd == CMD_REPORT);
    assign o_sts.is_sweep  = (r_req.cmd == CMD_POLL_END);
    assign o_sts.any_rep   = (r_nrep != '0);
    assign o_sts.rep_cap   = (r_nrep < RW'(MAX_RESULTS));

    logic          ins, do_ins, is_dis, hit_ok, rapid;
    logic [IW-1:0] tgt;
    logic [31:0]   per, dt, lim;
    assign ins    = (r_req.cmd == CMD_POLL) || (r_req.cmd == CMD_CONNECT);
    assign do_ins = ins && !r_hit && r_free_ok;
    assign hit_ok = r_hit || do_ins;
    assign tgt    = r_hit ? r_hit_idx : r_free_idx;
    assign is_dis = (r_req.cmd == CMD_DISCON) || (r_req.cmd == CMD_DEAUTH);
    assign per    = {24'd0, r_period};
    assign lim    = {16'd0, r_req.ap_id[0] ? r_lim1 : r_lim0};
    assign dt     = r_req.now_seconds - (do_ins ? 32'd0 : m_lct[tgt]);
    assign rapid  = (!do_ins && r_req.now_seconds < m_lct[tgt]) || (dt <= lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_seen <= '0;
        end else begin
            if (i_ctl.apply && do_ins) begin
                r_used[tgt] <= 1'b1;
            end
            if (i_ctl.apply && hit_ok && r_req.cmd == CMD_POLL) begin
                r_seen[tgt] <= 1'b1;
            end
            if (i_ctl.sweep && match) begin
                r_seen[idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_req     <= i_req;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_nrep    <= '0;
            r_rsp     <= '0;
        end
        if (i_ctl.clr_idx) begin
            r_idx <= '0;
        end else if (i_ctl.scan || i_ctl.sweep || i_ctl.rep_wr) begin
            if (!at_end) r_idx <= r_idx + 1'b1;
        end
        if (i_ctl.scan && match && m_mac[idx] == r_req.station_mac && !r_hit) begin
            r_hit     <= 1'b1;
            r_hit_idx <= idx;
        end
        if (i_ctl.scan && !r_used[idx] && !r_free_ok) begin
            r_free_ok  <= 1'b1;
            r_free_idx <= idx;
        end
        if (i_ctl.apply) begin
            if (r_req.cmd == CMD_DEAUTH) r_rsp.password_fail <= (r_req.reason == REASON_PASSWORD);
            if (ins && !hit_ok) r_rsp.status <= ST_FULL;
            if (is_dis && !r_hit) r_rsp.status <= ST_NOT_FOUND;
            if (r_req.cmd == CMD_CONNECT && hit_ok) r_rsp.rapid_reconnect <= rapid;
        end
        if (i_ctl.rep_rd) begin
            r_rsp.entry_valid <= 1'b1;
            r_rsp.rep_mac <= m_mac[idx];
            r_rsp.rep_good_time <= m_good[idx];
            r_rsp.rep_bad_time <= m_bad[idx];
            r_rsp.rep_total_connected <= sat_add32(m_tcon[idx], m_con[idx]);
            r_rsp.rep_total_disconnected <= sat_add32(m_tdis[idx], m_dis[idx]);
            r_rsp.rep_reconnects <= m_rc[idx];
            r_nrep <= r_nrep + 1'b1;
        end
        if (i_ctl.rep_wr) begin
            r_rsp <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.apply && do_ins) begin
            m_ap[tgt]  <= r_req.ap_id;
            m_mac[tgt] <= r_req.station_mac;
        end
        if (i_ctl.apply && hit_ok) begin
            case (r_req.cmd)
                CMD_POLL: begin
                    if (r_req.signal >= r_thresh) begin
                        m_good[tgt] <= sat_add32(do_ins ? 32'd0 : m_good[tgt], per);
                        if (do_ins) m_bad[tgt] <= '0;
                    end else begin
                        m_bad[tgt] <= sat_add32(do_ins ? 32'd0 : m_bad[tgt], per);
                        if (do_ins) m_good[tgt] <= '0;
                    end
                    m_con[tgt] <= sat_add32(do_ins ? 32'd0 : m_con[tgt], per);
                    if (do_ins) begin
                        m_dis[tgt]  <= '0;
                        m_tcon[tgt] <= '0;
                        m_tdis[tgt] <= '0;
                        m_lct[tgt]  <= '0;
                        m_rc[tgt]   <= '0;
                    end
                end
                CMD_CONNECT: begin
                    m_tdis[tgt] <= do_ins ? 32'd0 : sat_add32(m_tdis[tgt], m_dis[tgt]);
                    m_dis[tgt]  <= '0;
                    m_lct[tgt]  <= r_req.now_seconds;
                    if (do_ins) begin
                        m_good[tgt] <= '0;
                        m_bad[tgt]  <= '0;
                        m_con[tgt]  <= '0;
                        m_tcon[tgt] <= '0;
                        m_rc[tgt]   <= rapid ? 16'd1 : 16'd0;
                    end else if (rapid && m_rc[tgt] != 16'hFFFF) begin
                        m_rc[tgt] <= m_rc[tgt] + 16'd1;
                    end
                end
                CMD_DISCON, CMD_DEAUTH: begin
                    m_tcon[tgt] <= sat_add32(m_tcon[tgt], m_con[tgt]);
                    m_con[tgt]  <= '0;
                end
                default: ;
            endcase
        end
        if (i_ctl.sweep && match && !r_seen[idx]) begin
            m_dis[idx] <= sat_add32(m_dis[idx], per);
        end
        if (i_ctl.rep_wr) begin
            m_tcon[idx] <= r_rsp.rep_total_connected;
            m_tdis[idx] <= r_rsp.rep_total_disconnected;
            m_con[idx]  <= '0;
            m_dis[idx]  <= '0;
            m_good[idx] <= '0;
            m_bad[idx]  <= '0;
        end
    end

    // any further matching entry beyond index
    logic rest_match;
    always_comb begin
        rest_match = 1'b0;
        for (int k = 0; k < ENTRIES; k++) begin
            if (k > int'(r_idx) && r_used[k] && m_ap[k] == r_req.ap_id) rest_match = 1'b1;
        end
    end

    always_comb begin
        o_rsp = r_rsp;
        if (i_out_last_en) begin
            o_rsp.last = 1'b1;
            if (discard) begin
                o_rsp = '0;
                o_rsp.status = ST_DISCARD;
                o_rsp.last   = 1'b1;
            end
        end else begin
            o_rsp.last = (r_idx == CW'(ENTRIES - 1)) ||
                         (r_nrep == RW'(MAX_RESULTS)) || !rest_match;
        end
    end

endmodule

>>> sv/station_link_stats_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// station_link_stats_table
// Per-station link statistics table keyed by access point and MAC.
// ----------------------------------------------------------------------------
// channel  direction  handshake                    payload
// in       input      i_in_valid / o_in_ready      t_req
// out      output     o_out_valid / i_out_ready    t_rsp
// cfg      input      i_cfg_valid / o_cfg_ready    index, data
//
// Lookup walks all entries, one per cycle.
// Poll end and report also walk the table; report holds at each entry out until it is taken.
// Reset clears valid and seen bits and the configuration registers.
// An output stall holds the sequencer; no new request is taken until done.
// ----------------------------------------------------------------------------
module station_link_stats_table import slst_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES,
    parameter int NUM_AP  = DEF_NUM_AP
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_req                 i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_rsp                 o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    t_ctl ctl;
    t_sts sts;
    logic last_en;

    assign o_cfg_ready = 1'b1;

    slst_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_out_ready, .o_out_valid,
        .o_out_last_en(last_en), .i_sts(sts), .o_ctl(ctl)
    );

    slst_dp #(.ENTRIES(ENTRIES), .NUM_AP(NUM_AP)) u_dp (
        .i_clk, .i_rst_n, .i_req(i_in_data), .i_ctl(ctl), .i_out_last_en(last_en),
        .i_cfg_index, .i_cfg_data, .i_cfg_we(i_cfg_valid), .o_sts(sts), .o_rsp(o_out_data)
    );

    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid) else $error("result dropped");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready) else $error("second request taken");

endmodule
